FILE: hdl/oaht_pkg.sv
`timescale 1ns / 1ps
package oaht_pkg;

   localparam int KIND_W  = 2;
   localparam int DATA_W  = 64;
   localparam int COUNT_W = 14;

   localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONZERO = 2'd3;

   localparam int STEP_COST = 6;
   localparam int BIG_TABLE = 50000;
   localparam int MAX_LOG   = 16;

   typedef struct packed {
      logic req_ready;
      logic load_req;
      logic probe_main;
      logic probe_re;
      logic probe_rd;
      logic probe_next;
      logic wr_main;
      logic wr_re;
      logic clr_one;
      logic clr_full;
      logic ins;
      logic sweep_rd;
      logic grow_start;
      logic reh_start;
      logic grow_done;
      logic cnt_start;
      logic cnt_acc;
      logic res_hit;
      logic res_full;
      logic res_cnt_n;
      logic res_cnt_nz;
      logic rsp_push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic              req_valid;
      logic [KIND_W-1:0] req_kind;
      logic [KIND_W-1:0] kind;
      logic              hit;
      logic              empty;
      logic              exhausted;
      logic              room_ok;
      logic              can_grow;
      logic              sweep_last;
      logic              sweep_done;
      logic              occ;
      logic              rsp_free;
   } dp_status_type;

endpackage

FILE: hdl/oaht_ifs.sv
`timescale 1ns / 1ps
interface oaht_req_if;
   logic                         valid;
   logic                         ready;
   logic [oaht_pkg::KIND_W-1:0]  kind;
   logic [oaht_pkg::DATA_W-1:0]  key;
   logic [oaht_pkg::DATA_W-1:0]  value;
   modport source (output valid, kind, key, value, input ready);
   modport sink (input valid, kind, key, value, output ready);
endinterface

interface oaht_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [oaht_pkg::DATA_W-1:0]   read_value;
   logic [oaht_pkg::COUNT_W-1:0]  count;
   logic                          status;
   modport source (output valid, read_value, count, status, input ready);
   modport sink (input valid, read_value, count, status, output ready);
endinterface

FILE: hdl/oaht_ram.sv
`timescale 1ns / 1ps
module oaht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

FILE: hdl/oaht_ctrl.sv
`timescale 1ns / 1ps
module oaht_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  oaht_pkg::dp_status_type status,
   output oaht_pkg::ctrl_cmd_type  cmd
);
   import oaht_pkg::*;

   localparam logic [3:0] S_CLR_ALL = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_PINIT   = 4'd2;
   localparam logic [3:0] S_PRD     = 4'd3;
   localparam logic [3:0] S_PEV     = 4'd4;
   localparam logic [3:0] S_GCLR    = 4'd5;
   localparam logic [3:0] S_RRD     = 4'd6;
   localparam logic [3:0] S_REV     = 4'd7;
   localparam logic [3:0] S_RPRD    = 4'd8;
   localparam logic [3:0] S_RPEV    = 4'd9;
   localparam logic [3:0] S_GDONE   = 4'd10;
   localparam logic [3:0] S_CRD     = 4'd11;
   localparam logic [3:0] S_CEV     = 4'd12;
   localparam logic [3:0] S_CFIN    = 4'd13;
   localparam logic [3:0] S_RESP    = 4'd14;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLR_ALL: begin
            cmd.clr_one  = 1'b1;
            cmd.clr_full = 1'b1;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (status.req_valid) begin
               cmd.load_req = 1'b1;
               unique case (status.req_kind) inside
                  KIND_READ, KIND_WRITE: state_in = S_PINIT;
                  KIND_COUNT: begin
                     cmd.res_cnt_n = 1'b1;
                     state_in = S_RESP;
                  end
                  default: begin
                     cmd.cnt_start = 1'b1;
                     state_in = S_CRD;
                  end
               endcase
            end
         end
         S_PINIT: begin
            cmd.probe_main = 1'b1;
            state_in = S_PRD;
         end
         S_PRD: begin
            cmd.probe_rd = 1'b1;
            state_in = S_PEV;
         end
         S_PEV: begin
            if (status.hit) begin
               cmd.res_hit = 1'b1;
               cmd.wr_main = (status.kind == KIND_WRITE);
               state_in = S_RESP;
            end else if (status.empty) begin
               if (status.room_ok) begin
                  cmd.wr_main = 1'b1;
                  cmd.ins     = 1'b1;
                  state_in = S_RESP;
               end else if (status.can_grow) begin
                  cmd.grow_start = 1'b1;
                  state_in = S_GCLR;
               end else begin
                  cmd.res_full = 1'b1;
                  state_in = S_RESP;
               end
            end else if (status.exhausted) begin
               cmd.res_full = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.probe_next = 1'b1;
               state_in = S_PRD;
            end
         end
         S_GCLR: begin
            cmd.clr_one = 1'b1;
            if (status.sweep_last) begin
               cmd.reh_start = 1'b1;
               state_in = S_RRD;
            end
         end
         S_RRD: begin
            cmd.sweep_rd = 1'b1;
            state_in = S_REV;
         end
         S_REV: begin
            if (status.occ) begin
               cmd.probe_re = 1'b1;
               state_in = S_RPRD;
            end else if (status.sweep_done) begin
               state_in = S_GDONE;
            end else begin
               state_in = S_RRD;
            end
         end
         S_RPRD: begin
            cmd.probe_rd = 1'b1;
            state_in = S_RPEV;
         end
         S_RPEV: begin
            if (status.empty) begin
               cmd.wr_re = 1'b1;
               state_in = status.sweep_done ? S_GDONE : S_RRD;
            end else if (status.hit || status.exhausted) begin
               cmd.res_full = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.probe_next = 1'b1;
               state_in = S_RPRD;
            end
         end
         S_GDONE: begin
            cmd.grow_done = 1'b1;
            state_in = S_PINIT;
         end
         S_CRD: begin
            cmd.sweep_rd = 1'b1;
            state_in = S_CEV;
         end
         S_CEV: begin
            cmd.cnt_acc = 1'b1;
            state_in = status.sweep_done ? S_CFIN : S_CRD;
         end
         S_CFIN: begin
            cmd.res_cnt_nz = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_ALL;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

FILE: hdl/oaht_dp.sv
`timescale 1ns / 1ps
module oaht_dp #(
   parameter int MAX_SLOTS     = 8192,
   parameter int INITIAL_SLOTS = 8,
   parameter int KEY_WIDTH     = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   oaht_req_if.sink                req_ch,
   oaht_rsp_if.source              rsp_ch,
   input  oaht_pkg::ctrl_cmd_type  cmd,
   output oaht_pkg::dp_status_type status
);
   import oaht_pkg::*;

   localparam int AW      = $clog2(MAX_SLOTS);
   localparam int RA      = AW + 1;
   localparam int JW      = AW + 2;
   localparam int SZW     = AW + 1;
   localparam int LGW     = 5;
   localparam int NW      = $clog2(MAX_SLOTS + 1);
   localparam int RCW     = $clog2(4 * MAX_SLOTS + 2);
   localparam int WW      = 1 + KEY_WIDTH + DATA_W;
   localparam int INIT_LG = $clog2(INITIAL_SLOTS + 1) - 1;
   localparam int INIT_RC = 4 * (2 ** INIT_LG) + 1;

   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [DATA_W-1:0]    val_ff, val_in;
   logic                 bank_ff, bank_in;
   logic [LGW-1:0]       lg_ff, lg_in;
   logic [RCW-1:0]       rc_ff, rc_in;
   logic [NW-1:0]        n_ff, n_in;
   logic                 tbank_ff, tbank_in;
   logic [LGW-1:0]       tlg_ff, tlg_in;
   logic [KEY_WIDTH-1:0] pkey_ff, pkey_in;
   logic [KEY_WIDTH-1:0] pert_ff, pert_in;
   logic [AW-1:0]        i_ff, i_in;
   logic [AW-1:0]        pmask_ff, pmask_in;
   logic                 pbank_ff, pbank_in;
   logic [JW-1:0]        steps_ff, steps_in;
   logic [JW-1:0]        j_ff, j_in;
   logic [JW-1:0]        lim_ff, lim_in;
   logic [DATA_W-1:0]    hold_ff, hold_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [DATA_W-1:0]    res_value_ff, res_value_in;
   logic [COUNT_W-1:0]   res_count_ff, res_count_in;
   logic                 res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 ram_we, ram_re;
   logic [RA-1:0]        ram_waddr, ram_raddr;
   logic [WW-1:0]        ram_wdata, ram_rdata;

   logic                 r_occ;
   logic [KEY_WIDTH-1:0] r_key;
   logic [DATA_W-1:0]    r_val;
   logic [SZW-1:0]       size_w, tsize_w;
   logic [LGW-1:0]       new_lg;
   logic [AW-1:0]        i5, i_nxt;
   logic [RA-1:0]        probe_addr;
   logic                 rsp_free;

   oaht_ram #(.WIDTH(WW), .DEPTH(2 ** RA)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign r_occ = ram_rdata[WW-1];
   assign r_key = ram_rdata[DATA_W +: KEY_WIDTH];
   assign r_val = ram_rdata[DATA_W-1:0];

   assign size_w  = {{(SZW-1){1'b0}}, 1'b1} << lg_ff;
   assign tsize_w = {{(SZW-1){1'b0}}, 1'b1} << tlg_ff;
   assign new_lg  = lg_ff + ((32'(size_w) < BIG_TABLE) ? LGW'(2) : LGW'(1));
   assign i5      = AW'({i_ff, 2'b00}) + i_ff;
   assign i_nxt   = (i5 + AW'(pert_ff) + AW'(1)) & pmask_ff;
   assign probe_addr = {pbank_ff, i_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   assign status.req_valid  = req_ch.valid;
   assign status.req_kind   = req_ch.kind;
   assign status.kind       = kind_ff;
   assign status.hit        = r_occ && (r_key == pkey_ff);
   assign status.empty      = !r_occ;
   assign status.exhausted  = steps_ff == (JW'(pmask_ff) + JW'(16));
   assign status.room_ok    = rc_ff > RCW'(STEP_COST);
   assign status.can_grow   = (new_lg <= LGW'(MAX_LOG)) &&
                              ((32'(1) << new_lg) <= 32'(MAX_SLOTS));
   assign status.sweep_last = j_ff == (lim_ff - JW'(1));
   assign status.sweep_done = j_ff == lim_ff;
   assign status.occ        = r_occ;
   assign status.rsp_free   = rsp_free;

   assign req_ch.ready      = cmd.req_ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_value_ff;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.status     = rsp_status_ff;

   always_comb begin
      ram_we    = cmd.wr_main || cmd.wr_re || cmd.clr_one;
      ram_waddr = probe_addr;
      ram_wdata = '0;
      if (cmd.clr_one) begin
         ram_waddr = cmd.clr_full ? j_ff[RA-1:0] : {tbank_ff, j_ff[AW-1:0]};
      end else if (cmd.wr_re) begin
         ram_wdata = {1'b1, pkey_ff, hold_ff};
      end else begin
         ram_wdata = {1'b1, pkey_ff, (kind_ff == KIND_WRITE) ? val_ff : {DATA_W{1'b0}}};
      end
      ram_re    = cmd.probe_rd || cmd.sweep_rd;
      ram_raddr = cmd.probe_rd ? probe_addr : {bank_ff, j_ff[AW-1:0]};
   end

   always_comb begin
      kind_in       = kind_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      bank_in       = bank_ff;
      lg_in         = lg_ff;
      rc_in         = rc_ff;
      n_in          = n_ff;
      tbank_in      = tbank_ff;
      tlg_in        = tlg_ff;
      pkey_in       = pkey_ff;
      pert_in       = pert_ff;
      i_in          = i_ff;
      pmask_in      = pmask_ff;
      pbank_in      = pbank_ff;
      steps_in      = steps_ff;
      j_in          = j_ff;
      lim_in        = lim_ff;
      hold_in       = hold_ff;
      cnt_in        = cnt_ff;
      res_value_in  = res_value_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load_req) begin
         kind_in       = req_ch.kind;
         key_in        = req_ch.key[KEY_WIDTH-1:0];
         val_in        = req_ch.value;
         res_value_in  = '0;
         res_count_in  = '0;
         res_status_in = 1'b0;
      end
      if (cmd.res_cnt_n) res_count_in = COUNT_W'(n_ff);
      if (cmd.res_cnt_nz) res_count_in = COUNT_W'(cnt_ff);
      if (cmd.res_hit && kind_ff == KIND_READ) res_value_in = r_val;
      if (cmd.res_full) res_status_in = 1'b1;

      if (cmd.probe_main) begin
         pkey_in  = key_ff;
         pert_in  = key_ff;
         pmask_in = AW'(size_w - SZW'(1));
         i_in     = AW'(key_ff) & AW'(size_w - SZW'(1));
         pbank_in = bank_ff;
         steps_in = '0;
      end
      if (cmd.probe_re) begin
         pkey_in  = r_key;
         pert_in  = r_key;
         hold_in  = r_val;
         pmask_in = AW'(tsize_w - SZW'(1));
         i_in     = AW'(r_key) & AW'(tsize_w - SZW'(1));
         pbank_in = tbank_ff;
         steps_in = '0;
      end
      if (cmd.probe_next) begin
         i_in     = i_nxt;
         pert_in  = pert_ff >> 5;
         steps_in = steps_ff + JW'(1);
      end

      if (cmd.ins) begin
         rc_in = rc_ff - RCW'(STEP_COST);
         n_in  = n_ff + NW'(1);
      end
      if (cmd.clr_one || cmd.sweep_rd) j_in = j_ff + JW'(1);
      if (cmd.grow_start) begin
         j_in     = '0;
         lim_in   = JW'(32'(1) << new_lg);
         tbank_in = !bank_ff;
         tlg_in   = new_lg;
      end
      if (cmd.reh_start || cmd.cnt_start) begin
         j_in   = '0;
         lim_in = JW'(size_w);
      end
      if (cmd.cnt_start) cnt_in = '0;
      if (cmd.cnt_acc && r_occ && r_val != '0) cnt_in = cnt_ff + NW'(1);
      if (cmd.grow_done) begin
         bank_in = tbank_ff;
         lg_in   = tlg_ff;
         rc_in   = RCW'((32'(tsize_w) << 2) + 32'(1) - 32'(n_ff) * 32'(STEP_COST));
      end

      if (cmd.rsp_push) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_count_in  = res_count_ff;
         rsp_status_in = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         lg_ff        <= LGW'(INIT_LG);
         rc_ff        <= RCW'(INIT_RC);
         n_ff         <= '0;
         j_ff         <= '0;
         lim_ff       <= JW'(1) << RA;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         lg_ff        <= lg_in;
         rc_ff        <= rc_in;
         n_ff         <= n_in;
         j_ff         <= j_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      tbank_ff      <= tbank_in;
      tlg_ff        <= tlg_in;
      pkey_ff       <= pkey_in;
      pert_ff       <= pert_in;
      i_ff          <= i_in;
      pmask_ff      <= pmask_in;
      pbank_ff      <= pbank_in;
      steps_ff      <= steps_in;
      hold_ff       <= hold_in;
      cnt_ff        <= cnt_in;
      res_value_ff  <= res_value_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end
endmodule

FILE: hdl/open_address_hash_table.sv
`timescale 1ns / 1ps
// open-addressing hash table with perturbed probing, two banks of slots
// requests arrive on req_ch (kind, key, value) and each gives exactly one
// response on rsp_ch (read_value, count, status), in request order
// one request is in work at a time; req_ch.ready is high only while idle,
// and a finished response waits in the output register while the next
// request is taken
// a read or write walks its probe sequence through the slot ram
// (one read port, registered read), then queues its response
// a growth clears the new_size slots of the other bank, sweeps every old
// slot and probes each moved entry into the new bank, then finishes and probes again;
// entry count is answered from a register; nonzero count
// sweeps every slot of the active bank
// after reset a clearing pass over all 2 * 2**clog2(MAX_SLOTS) slots runs
// through the slot ram before the first request is taken
// a stalled rsp_ch holds the response; the next request then waits in its
// response state until the output register frees
module open_address_hash_table #(
   parameter int MAX_SLOTS     = 8192,
   parameter int INITIAL_SLOTS = 8,
   parameter int KEY_WIDTH     = 64
) (
   input  logic       clock,
   input  logic       reset,
   oaht_req_if.sink   req_ch,
   oaht_rsp_if.source rsp_ch
);
   import oaht_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   oaht_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   oaht_dp #(
      .MAX_SLOTS     (MAX_SLOTS),
      .INITIAL_SLOTS (INITIAL_SLOTS),
      .KEY_WIDTH     (KEY_WIDTH)
   ) u_dp (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );
endmodule
